### hw/rtl/tacd_pkg.sv
// Shared types and constants for the timestamp audit clock discipline block.
// No dependencies; every other file of the block imports this package.
package tacd_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int TIME_W     = 64;
	localparam int RATIO_W    = 32;
	localparam int MUL_B_W    = 32;
	localparam int MUL_ACC_W  = TIME_W + MUL_B_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DRIFT_MARGIN = 3'd0,
		CFG_MIN_PLAUS    = 3'd1,
		CFG_CALIB_IVL    = 3'd2,
		CFG_FAIL_LIMIT   = 3'd3,
		CFG_EMA_WEIGHT   = 3'd4
	} cfg_idx_t;

	localparam logic [19:0] DRIFT_MARGIN_RST = 20'd500;
	localparam logic [63:0] MIN_PLAUS_RST    = 64'd300000000;
	localparam logic [31:0] CALIB_IVL_RST    = 32'd4000000;
	localparam logic [3:0]  FAIL_LIMIT_RST   = 4'd5;
	localparam logic [16:0] EMA_WEIGHT_RST   = 17'd6554;
	localparam logic [16:0] EMA_ONE          = 17'd65536;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXTRAP,
		ST_AUDIT,
		ST_DIV,
		ST_EMA1,
		ST_EMA2,
		ST_OUT
	} state_t;

	// Command to the shared multiply unit.
	typedef struct packed {
		logic start;
		logic accum;
	} mul_cmd_t;

endpackage

### hw/rtl/tacd_if.sv
// Handshake channel interfaces for the input events and the results.
// Depends on tacd_pkg for the field widths.
interface tacd_in_if;
	import tacd_pkg::*;
	logic              valid;
	logic              ready;
	logic              cmd;
	logic [1:0]        event_kind;
	logic [TIME_W-1:0] ref_time;
	logic [TIME_W-1:0] local_time;
	modport source (output valid, cmd, event_kind, ref_time, local_time, input ready);
	modport sink (input valid, cmd, event_kind, ref_time, local_time, output ready);
endinterface

interface tacd_out_if;
	import tacd_pkg::*;
	logic              valid;
	logic              ready;
	logic [1:0]        kind_out;
	logic [TIME_W-1:0] time_out;
	logic              hold_mode;
	logic              forced_accept;
	logic [3:0]        fail_count_out;
	modport source (output valid, kind_out, time_out, hold_mode, forced_accept,
		fail_count_out, input ready);
	modport sink (input valid, kind_out, time_out, hold_mode, forced_accept,
		fail_count_out, output ready);
endinterface

### hw/rtl/tacd_mul.sv
// Iterative shift-and-add multiply-accumulate unit, one multiplier bit per cycle.
// Depends on tacd_pkg for widths and the command struct.
module tacd_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tacd_pkg::mul_cmd_t            cmd,
	input  logic [tacd_pkg::TIME_W-1:0]   a,
	input  logic [tacd_pkg::MUL_B_W-1:0]  b,
	output logic                          done,
	output logic [tacd_pkg::MUL_ACC_W-1:0] acc
);
	import tacd_pkg::*;

	localparam int CNT_W = $clog2(MUL_B_W);

	logic                 busy_q, done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [MUL_ACC_W-1:0] a_q, acc_q;
	logic [MUL_B_W-1:0]   b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(MUL_B_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			a_q <= MUL_ACC_W'(a);
			b_q <= b;
			if (!cmd.accum) acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0]) acc_q <= acc_q + a_q;
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign done = done_q;
	assign acc  = acc_q;
endmodule

### hw/rtl/tacd_div.sv
// Restoring bit-serial divider: floor(n * 2^FRAC / d), saturated to 32 bits.
// Depends on tacd_pkg for widths.
module tacd_div #(
	parameter int FRAC = 30
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [tacd_pkg::TIME_W-1:0]   n,
	input  logic [tacd_pkg::TIME_W-1:0]   d,
	output logic                          done,
	output logic [tacd_pkg::RATIO_W-1:0]  q
);
	import tacd_pkg::*;

	localparam int NUM_W = TIME_W + FRAC;
	localparam int CNT_W = $clog2(NUM_W);

	logic                 busy_q, done_q, ovf_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [NUM_W-1:0]     num_q;
	logic [TIME_W-1:0]    den_q, rem_q;
	logic [RATIO_W-1:0]   quo_q;
	logic [TIME_W:0]      rem_sh;
	logic                 fits;

	assign rem_sh = {rem_q, num_q[NUM_W-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {n, {FRAC{1'b0}}};
			den_q <= d;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= fits ? TIME_W'(rem_sh - {1'b0, den_q}) : rem_sh[TIME_W-1:0];
			quo_q <= {quo_q[RATIO_W-2:0], fits};
			// A set bit shifted out of the quotient means the result exceeds 32 bits.
			if (quo_q[RATIO_W-1]) ovf_q <= 1'b1;
		end
	end

	assign done = done_q;
	assign q    = ovf_q ? '1 : quo_q;
endmodule

### hw/rtl/timestamp_audit_clock_discipline.sv
// Clock discipline with holdover and a smoothed rate estimate: top level.
// Depends on tacd_pkg, tacd_if, tacd_mul and tacd_div.
//
// Usage: each input transaction on in_ch carries a command, an event kind, an
// observed reference time and a local time. A timestamp event produces at most
// one result transaction on out_ch with the reported time and its mode; a
// resync command produces none. Configuration registers are written through
// cfg_we, cfg_index and cfg_wdata; the user must write them only while the
// block is idle, as the block itself does not enforce this. Sequencing: one
// event at a time, and in_ch.ready is high only in the idle state. A locking
// event goes to the output state and back to idle; a resync, or an event that
// gives no result, stays in idle. A holdover event first runs the shared
// shift-add multiplier to extrapolate, and an audit then adds the audit state.
// A re-estimate adds the bit-serial divider and, once the rate is calibrated,
// two further multiplies for the moving average before the output state.
// Reset clears the baseline, calibration, failure count and restores the
// configuration defaults and a rate ratio of one.
// The result sits in an output register; when the receiver stalls, the block
// holds the finished result and waits before returning to idle.
module timestamp_audit_clock_discipline #(
	parameter int RATIO_FRAC_BITS = 30
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tacd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tacd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	tacd_in_if.sink                          in_ch,
	tacd_out_if.source                       out_ch
);
	import tacd_pkg::*;

	// Configuration registers.
	logic [19:0] margin_q;
	logic [63:0] min_plaus_q;
	logic [31:0] calib_ivl_q;
	logic [3:0]  fail_limit_q;
	logic [16:0] weight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q     <= DRIFT_MARGIN_RST;
			min_plaus_q  <= MIN_PLAUS_RST;
			calib_ivl_q  <= CALIB_IVL_RST;
			fail_limit_q <= FAIL_LIMIT_RST;
			weight_q     <= EMA_WEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DRIFT_MARGIN: margin_q     <= cfg_wdata[19:0];
				CFG_MIN_PLAUS:    min_plaus_q  <= cfg_wdata;
				CFG_CALIB_IVL:    calib_ivl_q  <= cfg_wdata[31:0];
				CFG_FAIL_LIMIT:   fail_limit_q <= cfg_wdata[3:0];
				CFG_EMA_WEIGHT:   weight_q     <= cfg_wdata[16:0];
				default: ;
			endcase
		end
	end

	// Discipline state.
	state_t              state_q, state_d;
	logic                has_base_q, rate_cal_q, last_hold_q;
	logic [RATIO_W-1:0]  ratio_q;
	logic [TIME_W-1:0]   good_ref_q, good_loc_q, cal_ref_q, cal_loc_q;
	logic [3:0]          fail_q;

	// Current event and prepared result.
	logic [1:0]          kind_q;
	logic [TIME_W-1:0]   ref_q, loc_q, res_time_q;
	logic                res_mode_q, res_forced_q;

	// Output register.
	logic                ov_q;
	logic [1:0]          o_kind_q;
	logic [TIME_W-1:0]   o_time_q;
	logic                o_mode_q, o_forced_q;
	logic [3:0]          o_fail_q;

	// Shared units.
	mul_cmd_t            mcmd;
	logic [TIME_W-1:0]   m_a;
	logic [MUL_B_W-1:0]  m_b;
	logic                m_done;
	logic [MUL_ACC_W-1:0] m_acc;
	logic                d_start, d_done;
	logic [RATIO_W-1:0]  d_q;

	tacd_mul u_mul (
		.clk(clk), .arst_n(arst_n), .cmd(mcmd), .a(m_a), .b(m_b),
		.done(m_done), .acc(m_acc)
	);

	tacd_div #(.FRAC(RATIO_FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(d_start),
		.n(ref_q - cal_ref_q), .d(loc_q - cal_loc_q),
		.done(d_done), .q(d_q)
	);

	// Extrapolated time: scaled elapsed time saturated to 64 bits, then wrapped sum.
	logic [MUL_ACC_W-1:0] scaled;
	logic [TIME_W-1:0]    delta, expect_t, gap;
	logic                 gap_ok, cal_due;
	logic [16:0]          w_sat, w_cmp;
	logic [3:0]           fail_inc;
	logic                 out_free, accept;

	assign scaled   = m_acc >> RATIO_FRAC_BITS;
	assign delta    = (scaled[MUL_ACC_W-1:TIME_W] != '0) ? '1 : scaled[TIME_W-1:0];
	assign expect_t = good_ref_q + delta;
	assign gap      = (ref_q > res_time_q) ? ref_q - res_time_q : res_time_q - ref_q;
	assign gap_ok   = gap <= TIME_W'(margin_q);
	assign cal_due  = (cal_ref_q != '0) && ((loc_q - cal_loc_q) > TIME_W'(calib_ivl_q));
	assign w_sat    = (weight_q > EMA_ONE) ? EMA_ONE : weight_q;
	assign w_cmp    = EMA_ONE - w_sat;
	assign fail_inc = fail_q + 4'd1;
	assign out_free = !ov_q || out_ch.ready;
	assign accept   = in_ch.valid && in_ch.ready;

	assign in_ch.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// Next state and unit commands.
	always_comb begin
		state_d     = state_q;
		mcmd.start  = 1'b0;
		mcmd.accum  = 1'b0;
		m_a         = in_ch.local_time - good_loc_q;
		m_b         = MUL_B_W'(ratio_q);
		d_start     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && !in_ch.cmd) begin
					if (in_ch.ref_time != '0 && has_base_q) begin
						mcmd.start = 1'b1;
						state_d    = ST_EXTRAP;
					end else if (in_ch.ref_time != '0 && in_ch.ref_time >= min_plaus_q) begin
						state_d = ST_OUT;
					end else if (has_base_q) begin
						mcmd.start = 1'b1;
						state_d    = ST_EXTRAP;
					end
				end
			end
			ST_EXTRAP: begin
				if (m_done) state_d = (ref_q != '0) ? ST_AUDIT : ST_OUT;
			end
			ST_AUDIT: begin
				if (gap_ok && cal_due) begin
					d_start = 1'b1;
					state_d = ST_DIV;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_DIV: begin
				if (d_done) begin
					if (!rate_cal_q) begin
						state_d = ST_OUT;
					end else begin
						mcmd.start = 1'b1;
						m_a        = TIME_W'(d_q);
						m_b        = MUL_B_W'(w_sat);
						state_d    = ST_EMA1;
					end
				end
			end
			ST_EMA1: begin
				if (m_done) begin
					mcmd.start = 1'b1;
					mcmd.accum = 1'b1;
					m_a        = TIME_W'(ratio_q);
					m_b        = MUL_B_W'(w_cmp);
					state_d    = ST_EMA2;
				end
			end
			ST_EMA2: begin
				if (m_done) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State updates, taken as each step finishes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_base_q  <= 1'b0;
			rate_cal_q  <= 1'b0;
			last_hold_q <= 1'b0;
			ratio_q     <= RATIO_W'(64'd1 << RATIO_FRAC_BITS);
			good_ref_q  <= '0;
			good_loc_q  <= '0;
			cal_ref_q   <= '0;
			cal_loc_q   <= '0;
			fail_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && in_ch.cmd) begin
						// Resync after a holdover clears the baseline; the rate is kept.
						if (last_hold_q && in_ch.ref_time > min_plaus_q) begin
							has_base_q <= 1'b0;
							cal_ref_q  <= '0;
							cal_loc_q  <= '0;
							fail_q     <= '0;
						end
					end else if (accept && in_ch.ref_time != '0 && !has_base_q &&
						in_ch.ref_time >= min_plaus_q) begin
						has_base_q  <= 1'b1;
						cal_ref_q   <= in_ch.ref_time;
						cal_loc_q   <= in_ch.local_time;
						good_ref_q  <= in_ch.ref_time;
						good_loc_q  <= in_ch.local_time;
						last_hold_q <= 1'b0;
					end
				end
				ST_EXTRAP: begin
					if (m_done && ref_q == '0) begin
						good_ref_q  <= expect_t;
						good_loc_q  <= loc_q;
						last_hold_q <= 1'b1;
					end
				end
				ST_AUDIT: begin
					if (gap_ok) begin
						fail_q      <= '0;
						good_ref_q  <= ref_q;
						good_loc_q  <= loc_q;
						last_hold_q <= 1'b0;
						if (!cal_due) begin
							cal_ref_q <= ref_q;
							cal_loc_q <= loc_q;
						end
					end else if (fail_inc >= fail_limit_q) begin
						fail_q      <= '0;
						cal_ref_q   <= ref_q;
						cal_loc_q   <= loc_q;
						good_ref_q  <= ref_q;
						good_loc_q  <= loc_q;
						last_hold_q <= 1'b0;
					end else begin
						fail_q      <= fail_inc;
						good_ref_q  <= res_time_q;
						good_loc_q  <= loc_q;
						last_hold_q <= 1'b1;
					end
				end
				ST_DIV: begin
					if (d_done && !rate_cal_q) begin
						ratio_q    <= d_q;
						rate_cal_q <= 1'b1;
						cal_ref_q  <= ref_q;
						cal_loc_q  <= loc_q;
					end
				end
				ST_EMA2: begin
					if (m_done) begin
						ratio_q   <= m_acc[RATIO_W+15:16];
						cal_ref_q <= ref_q;
						cal_loc_q <= loc_q;
					end
				end
				default: ;
			endcase
		end
	end

	// Event capture and result preparation.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q       <= in_ch.event_kind;
			ref_q        <= in_ch.ref_time;
			loc_q        <= in_ch.local_time;
			res_time_q   <= in_ch.ref_time;
			res_mode_q   <= 1'b0;
			res_forced_q <= 1'b0;
		end else if (state_q == ST_EXTRAP && m_done) begin
			// Holds the expected time for the audit, and the holdover time otherwise.
			res_time_q <= expect_t;
			res_mode_q <= 1'b1;
		end else if (state_q == ST_AUDIT) begin
			if (gap_ok) begin
				res_time_q <= ref_q;
				res_mode_q <= 1'b0;
			end else if (fail_inc >= fail_limit_q) begin
				res_time_q   <= ref_q;
				res_mode_q   <= 1'b0;
				res_forced_q <= 1'b1;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			ov_q <= 1'b1;
		end else if (out_ch.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			o_kind_q   <= kind_q;
			o_time_q   <= res_time_q;
			o_mode_q   <= res_mode_q;
			o_forced_q <= res_forced_q;
			o_fail_q   <= fail_q;
		end
	end

	assign out_ch.valid          = ov_q;
	assign out_ch.kind_out       = o_kind_q;
	assign out_ch.time_out       = o_time_q;
	assign out_ch.hold_mode      = o_mode_q;
	assign out_ch.forced_accept  = o_forced_q;
	assign out_ch.fail_count_out = o_fail_q;
endmodule
